// ===== sv/clctw_pkg.sv =====
// Shared types, constants and helper functions for the character LCD text and cursor writer.
package clctw_pkg;

  // Field widths of the stream and configuration words.
  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned NibbleWidth  = 4;
  localparam int unsigned ColsWidth    = 6;
  localparam int unsigned RowsWidth    = 3;
  localparam int unsigned RowWidth     = 2;
  localparam int unsigned InDataWidth  = 3 * ByteWidth;
  localparam int unsigned OutDataWidth = 8;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = ColsWidth;

  // Display constants.
  localparam logic [ByteWidth-1:0] NewlineCode = 8'h0A;
  localparam logic [ByteWidth-1:0] SetDdramCmd = 8'h80;
  localparam logic [ColsWidth-1:0] ColsReset   = 6'd20;
  localparam logic [RowsWidth-1:0] RowsReset   = 3'd4;

  // Input item kinds; the fourth code is unused and ignored.
  typedef enum logic [CmdWidth-1:0] {
    CMD_TEXT  = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_GLYPH = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COLUMNS     = 1'b0,
    REG_ROWS_IN_USE = 1'b1
  } cfg_reg_e;

  // Register-select values on the panel bus.
  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;

  // One classified item: one or two bytes, each with its register-select flag.
  typedef struct packed {
    logic                 two_bytes;
    logic                 rs0;
    logic [ByteWidth-1:0] byte0;
    logic                 rs1;
    logic [ByteWidth-1:0] byte1;
  } job_t;

  // DDRAM start address of each display row.
  function automatic logic [ByteWidth-1:0] row_base(input logic [RowWidth-1:0] row);
    logic [ByteWidth-1:0] base;
    unique case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  // Set-address command byte for a column and a row.
  function automatic logic [ByteWidth-1:0] addr_cmd(input logic [ByteWidth-1:0] col,
                                                     input logic [RowWidth-1:0]  row);
    return SetDdramCmd | (col + row_base(row));
  endfunction

endpackage

// ===== sv/clctw_front.sv =====
// Front end: accepts input words, tracks the cursor and turns each item into a byte job.
module clctw_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  input  logic [clctw_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [clctw_pkg::CfgDataWidth-1:0] cfg_data_i,
  // Input item
  input  logic                              accept_i,
  input  logic [clctw_pkg::CmdWidth-1:0]    cmd_i,
  input  logic [clctw_pkg::ByteWidth-1:0]   char_code_i,
  input  logic [clctw_pkg::ByteWidth-1:0]   target_col_i,
  input  logic [clctw_pkg::ByteWidth-1:0]   target_row_i,
  // Job toward the queue
  output logic                              push_o,
  output clctw_pkg::job_t                   job_o
);

  logic [clctw_pkg::ColsWidth-1:0] columns_q;
  logic [clctw_pkg::RowsWidth-1:0] rows_q;
  logic [clctw_pkg::ByteWidth-1:0] col_q, col_d;
  logic [clctw_pkg::RowWidth-1:0]  row_q, row_d;

  logic                            wrap;
  logic [clctw_pkg::RowWidth-1:0]  row_wrap, row_text, row_nl, row_tgt;
  logic [clctw_pkg::ByteWidth-1:0] col_text;
  logic                            has_job;
  clctw_pkg::job_t                 job;

  // A row at or past the rows in use, or past the last row, folds back to row 0.
  function automatic logic [clctw_pkg::RowWidth-1:0] norm_row(
      input logic [clctw_pkg::ByteWidth-1:0] r,
      input logic [clctw_pkg::RowsWidth-1:0] rows);
    logic [clctw_pkg::RowWidth-1:0] res;
    if (r >= {5'd0, rows} || r >= 8'd4) begin
      res = '0;
    end else begin
      res = r[clctw_pkg::RowWidth-1:0];
    end
    return res;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= clctw_pkg::ColsReset;
      rows_q    <= clctw_pkg::RowsReset;
    end else if (cfg_valid_i) begin
      unique case (clctw_pkg::cfg_reg_e'(cfg_index_i))
        clctw_pkg::REG_COLUMNS:     columns_q <= cfg_data_i;
        clctw_pkg::REG_ROWS_IN_USE: rows_q    <= cfg_data_i[clctw_pkg::RowsWidth-1:0];
        default: ;
      endcase
    end
  end

  // Row candidates for a text wrap, a newline and an explicit move.
  always_comb begin
    wrap     = col_q >= {2'd0, columns_q};
    row_wrap = norm_row({6'd0, row_q} + 8'd1, rows_q);
    row_text = wrap ? row_wrap : row_q;
    col_text = wrap ? '0 : col_q;
    row_nl   = norm_row({6'd0, row_text} + 8'd1, rows_q);
    row_tgt  = norm_row(target_row_i, rows_q);
  end

  // Classify the item into at most two bytes and the next cursor.
  always_comb begin
    has_job       = 1'b0;
    job.two_bytes = 1'b0;
    job.rs0       = clctw_pkg::RsCommand;
    job.byte0     = '0;
    job.rs1       = clctw_pkg::RsData;
    job.byte1     = '0;
    col_d         = col_q;
    row_d         = row_q;
    unique case (clctw_pkg::cmd_e'(cmd_i))
      clctw_pkg::CMD_TEXT: begin
        has_job = 1'b1;
        if (char_code_i == clctw_pkg::NewlineCode) begin
          col_d = '0;
          row_d = row_nl;
          if (wrap) begin
            job.two_bytes = 1'b1;
            job.byte0     = clctw_pkg::addr_cmd('0, row_wrap);
            job.rs1       = clctw_pkg::RsCommand;
            job.byte1     = clctw_pkg::addr_cmd('0, row_nl);
          end else begin
            job.byte0 = clctw_pkg::addr_cmd('0, row_nl);
          end
        end else begin
          col_d = col_text + 8'd1;
          row_d = row_text;
          if (wrap) begin
            job.two_bytes = 1'b1;
            job.byte0     = clctw_pkg::addr_cmd('0, row_wrap);
            job.byte1     = char_code_i;
          end else begin
            job.rs0   = clctw_pkg::RsData;
            job.byte0 = char_code_i;
          end
        end
      end
      clctw_pkg::CMD_MOVE: begin
        has_job   = 1'b1;
        job.byte0 = clctw_pkg::addr_cmd(target_col_i, row_tgt);
        col_d     = target_col_i;
        row_d     = row_tgt;
      end
      clctw_pkg::CMD_GLYPH: begin
        has_job       = 1'b1;
        job.two_bytes = 1'b1;
        job.byte0     = clctw_pkg::addr_cmd(target_col_i, row_tgt);
        job.byte1     = char_code_i;
        col_d         = target_col_i;
        row_d         = row_tgt;
      end
      default: ;
    endcase
  end

  // Cursor registers move on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o = accept_i && has_job;
  assign job_o  = job;

endmodule

// ===== sv/clctw_queue.sv =====
// Short job queue between the front end and the nibble serializer.
module clctw_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clctw_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output clctw_pkg::job_t job_o
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

  clctw_pkg::job_t     mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] count_q;

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign full_o  = count_q == DepthCnt;
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

endmodule

// ===== sv/clctw_back.sv =====
// Back end: splits the queued bytes into nibble words, high nibble first.
module clctw_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  input  clctw_pkg::job_t                     job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_rs_o,
  output logic [clctw_pkg::NibbleWidth-1:0]   out_nibble_o,
  output logic                                out_last_o
);

  // Bit 1 selects the byte, bit 0 the low nibble.
  logic [1:0]                      nib_idx_q;
  logic [clctw_pkg::ByteWidth-1:0] cur_byte;
  logic                            word_done;

  always_comb begin
    cur_byte     = nib_idx_q[1] ? job_i.byte1 : job_i.byte0;
    out_rs_o     = nib_idx_q[1] ? job_i.rs1 : job_i.rs0;
    out_nibble_o = nib_idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    out_last_o   = nib_idx_q[0] && (nib_idx_q[1] || !job_i.two_bytes);
    out_valid_o  = job_valid_i;
    word_done    = job_valid_i && out_ready_i;
    pop_o        = word_done && out_last_o;
  end

  // Nibble position within the current job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_idx_q <= '0;
    end else if (word_done) begin
      nib_idx_q <= out_last_o ? 2'd0 : nib_idx_q + 2'd1;
    end
  end

endmodule

// ===== sv/char_lcd_text_cursor_writer.sv =====
// Top level of the character LCD text and cursor writer.
// Takes text characters, cursor moves and custom-glyph puts, keeps the cursor, and
// produces the 4-bit bus writes for a character LCD panel: each byte becomes two
// output words, high nibble first, with tuser carrying register select (0 command,
// 1 data) and tlast marking the final word of an input item. An item yields zero
// (unused command code), two or four words. The front end classifies an input word
// in the cycle it is accepted and takes a new one every cycle while the job queue
// (QueueDepth entries) has room; the back end sends one word per cycle while the output
// is ready, and it starts a job only after the last word of the previous one, so the
// nibble serializer sets the sustained rate; wraps before a character or newline and
// glyph puts are two-byte items. Configuration is always ready.
module char_lcd_text_cursor_writer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [clctw_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [clctw_pkg::CfgDataWidth-1:0]    cfg_data_i,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] char_code, [15:8] target_col, [23:16] target_row
  input  logic [clctw_pkg::InDataWidth-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [clctw_pkg::CmdWidth-1:0]        s_axis_tuser,
  // Output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] nibble, [7:4] zero
  output logic [clctw_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // [0] reg_select
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  logic                              full, job_valid, push, pop, accept;
  clctw_pkg::job_t                   job_in, job_head;
  logic [clctw_pkg::NibbleWidth-1:0] nibble;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  clctw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser),
    .char_code_i  (s_axis_tdata[7:0]),
    .target_col_i (s_axis_tdata[15:8]),
    .target_row_i (s_axis_tdata[23:16]),
    .push_o       (push),
    .job_o        (job_in)
  );

  clctw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  clctw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (m_axis_tuser),
    .out_nibble_o (nibble),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, nibble};

endmodule

// ===== sv/clctw_checker.sv =====
// Port-level checks for the character LCD text and cursor writer, bound to the top level.
module clctw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [clctw_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tlast
);

  // Tracks whether the next output word is the low nibble of a byte.
  logic low_half_q;
  logic first_rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_half_q <= 1'b0;
      first_rs_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      low_half_q <= !low_half_q;
      first_rs_q <= m_axis_tuser;
    end
  end

  // A stalled word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // An item always ends on the low nibble of a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !low_half_q |-> !m_axis_tlast)
    else $error("last flag on a high nibble");

  // Both nibbles of a byte carry the same register select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && low_half_q |-> m_axis_tuser == first_rs_q)
    else $error("register select changed within a byte");

  // Every command byte is a set-address command, so its high nibble has the top bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !low_half_q && !m_axis_tuser |-> m_axis_tdata[3])
    else $error("command byte is not a set-address command");

endmodule

bind char_lcd_text_cursor_writer clctw_checker u_clctw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
